// ----- hdl/dds_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the dense shortest-path engine.
// No dependencies.
package dds_pkg;

   localparam int NODE_W = 4;
   localparam int DIST_W = 30;
   localparam int PAR_W  = 5;
   localparam int RANK_W = 4;
   localparam int EWT_W  = 16;
   localparam int CNT_W  = 5;

   localparam logic [DIST_W-1:0]        INF_DIST     = 30'd1000000000;
   localparam logic signed [PAR_W-1:0]  PARENT_NONE  = -5'sd1;
   localparam logic [CNT_W-1:0]         NCOUNT_RESET = 5'd16;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_RUN   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEL,
      ST_SETTLE,
      ST_RELAX,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_SEND
   } dds_state_type;

endpackage

// ----- hdl/dds_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready plus payload).
// Depends on dds_pkg.
interface dds_req_if;
   import dds_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [NODE_W-1:0]   from_node;
   logic [NODE_W-1:0]   to_node;
   logic [EWT_W-1:0]    edge_weight;
   logic                edge_present;

   modport source (output valid, kind, from_node, to_node, edge_weight, edge_present,
                   input ready);
   modport sink   (input valid, kind, from_node, to_node, edge_weight, edge_present,
                   output ready);
endinterface

interface dds_rsp_if;
   import dds_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [NODE_W-1:0]         node_index;
   logic [DIST_W-1:0]         path_distance;
   logic signed [PAR_W-1:0]   parent_node;
   logic                      reached;
   logic [RANK_W-1:0]         visit_rank;
   logic                      last_result;

   modport source (output valid, node_index, path_distance, parent_node, reached,
                   visit_rank, last_result, input ready);
   modport sink   (input valid, node_index, path_distance, parent_node, reached,
                   visit_rank, last_result, output ready);
endinterface

// ----- hdl/dense_dijkstra_shortest_path_top.sv -----
`timescale 1ns / 1ps
// Dense single-source shortest paths over an adjacency-matrix memory.
// Write beat: one matrix entry. Run beat: per active node a select scan, settle
// step and relax scan, then a read, load and send per result beat (plus any rsp
// stall). The single distance read/compare/add unit, stepping one node a cycle,
// sets the throughput. Synchronous reset; after reset a clearing pass over every
// matrix entry empties it, with req not ready. Depends on dds_pkg, dds_if.
module dense_dijkstra_shortest_path_top #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   dds_req_if.sink                     req_if,
   dds_rsp_if.source                   rsp_if,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dds_pkg::CNT_W-1:0]   csr_node_count
);
   import dds_pkg::*;

   localparam int NB    = $clog2(MAX_NODES);
   localparam int CW    = $clog2(MAX_NODES + 1);
   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam int WW    = WEIGHT_BITS;

   dds_state_type state_ff, state_in;

   logic [CNT_W-1:0]      ncount_ff;
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         j_ff, j_in;
   logic                  p_vld_ff, p_vld_in;
   logic [NB-1:0]         p_idx_ff, p_idx_in;
   logic [NB-1:0]         sel_ff, sel_in;
   logic [NB-1:0]         cur_ff, cur_in;
   logic [DIST_W-1:0]     best_ff, best_in;
   logic                  found_ff, found_in;
   logic [MAX_NODES-1:0]  settled_ff, settled_in;
   logic [MAX_NODES-1:0]  relaxed_ff, relaxed_in;
   logic [AW-1:0]         clr_ff, clr_in;

   logic [NODE_W-1:0]       o_idx_ff, o_idx_in;
   logic [DIST_W-1:0]       o_dist_ff, o_dist_in;
   logic signed [PAR_W-1:0] o_par_ff, o_par_in;
   logic                    o_reach_ff, o_reach_in;
   logic [RANK_W-1:0]       o_rank_ff, o_rank_in;
   logic                    o_last_ff, o_last_in;

   logic [WW:0]           mat_mem [DEPTH];
   logic [WW:0]           mat_rd_ff;
   logic [DIST_W-1:0]     dist_mem [MAX_NODES];
   logic [DIST_W-1:0]     dist_rd_ff;
   logic [NB-1:0]         pred_mem [MAX_NODES];
   logic [NB-1:0]         pred_rd_ff;
   logic [NB-1:0]         rank_mem [MAX_NODES];
   logic [NB-1:0]         rank_rd_ff;

   logic                  mat_we;
   logic [AW-1:0]         mat_wa;
   logic [WW:0]           mat_wd;
   logic [AW-1:0]         mat_ra;
   logic                  dist_we;
   logic                  rank_we;
   logic                  rd_en;
   logic [NB-1:0]         rd_addr;

   logic                  req_acc;
   logic                  issue;
   logic                  scan_done;
   logic                  last_sel;
   logic                  last_out;
   logic                  wr_in_range;
   logic [DIST_W-1:0]     d_now;
   logic [DIST_W:0]       relax_sum;
   logic                  improve;
   logic                  sel_take;

   assign csr_ready = 1'b1;
   assign req_acc   = req_if.valid && req_if.ready;
   assign issue     = ((state_ff == ST_SEL) || (state_ff == ST_RELAX)) && (j_ff < n_ff);
   assign scan_done = (j_ff == n_ff);
   assign last_sel  = (CW'(sel_ff) + CW'(1)) == n_ff;
   assign last_out  = (j_ff + CW'(1)) == n_ff;
   assign rd_addr   = j_ff[NB-1:0];
   assign rd_en     = issue || (state_ff == ST_OUT_RD);
   assign mat_ra    = AW'(int'(cur_ff) * MAX_NODES + int'(j_ff));
   assign wr_in_range = (int'(req_if.from_node) < MAX_NODES) &&
                        (int'(req_if.to_node) < MAX_NODES);

   assign d_now     = relaxed_ff[p_idx_ff] ? dist_rd_ff :
                      ((p_idx_ff == '0) ? '0 : INF_DIST);
   assign relax_sum = {1'b0, best_ff} + (DIST_W+1)'(mat_rd_ff[WW-1:0]);
   assign improve   = mat_rd_ff[WW] && (relax_sum < {1'b0, d_now});
   assign sel_take  = !settled_ff[p_idx_ff] && (!found_ff || (d_now < best_ff));

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = (state_ff == ST_OUT_SEND);
   assign rsp_if.node_index    = o_idx_ff;
   assign rsp_if.path_distance = o_dist_ff;
   assign rsp_if.parent_node   = o_par_ff;
   assign rsp_if.reached       = o_reach_ff;
   assign rsp_if.visit_rank    = o_rank_ff;
   assign rsp_if.last_result   = o_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc && (req_if.kind == KIND_RUN)) state_in = ST_SEL;
         end
         ST_SEL: begin
            if (scan_done) state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            state_in = ST_RELAX;
         end
         ST_RELAX: begin
            if (scan_done) state_in = last_sel ? ST_OUT_RD : ST_SEL;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_if.ready) state_in = last_out ? ST_IDLE : ST_OUT_RD;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      n_in       = n_ff;
      j_in       = j_ff;
      p_vld_in   = issue;
      p_idx_in   = rd_addr;
      sel_in     = sel_ff;
      cur_in     = cur_ff;
      best_in    = best_ff;
      found_in   = found_ff;
      settled_in = settled_ff;
      relaxed_in = relaxed_ff;
      clr_in     = clr_ff;
      o_idx_in   = o_idx_ff;
      o_dist_in  = o_dist_ff;
      o_par_in   = o_par_ff;
      o_reach_in = o_reach_ff;
      o_rank_in  = o_rank_ff;
      o_last_in  = o_last_ff;
      mat_we     = 1'b0;
      mat_wa     = AW'(int'(req_if.from_node) * MAX_NODES + int'(req_if.to_node));
      mat_wd     = {req_if.edge_present, WW'(req_if.edge_weight)};
      dist_we    = 1'b0;
      rank_we    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mat_we = 1'b1;
            mat_wa = clr_ff;
            mat_wd = '0;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_if.kind == KIND_RUN) begin
                  if (ncount_ff == '0)
                     n_in = CW'(1);
                  else if (int'(ncount_ff) > MAX_NODES)
                     n_in = CW'(MAX_NODES);
                  else
                     n_in = CW'(ncount_ff);
                  j_in       = '0;
                  sel_in     = '0;
                  found_in   = 1'b0;
                  settled_in = '0;
                  relaxed_in = '0;
               end else if (wr_in_range) begin
                  mat_we = 1'b1;
               end
            end
         end
         ST_SEL: begin
            if (issue) j_in = j_ff + CW'(1);
            if (p_vld_ff && sel_take) begin
               best_in  = d_now;
               cur_in   = p_idx_ff;
               found_in = 1'b1;
            end
            if (scan_done) j_in = '0;
         end
         ST_SETTLE: begin
            settled_in[cur_ff] = 1'b1;
            rank_we            = 1'b1;
         end
         ST_RELAX: begin
            if (issue) j_in = j_ff + CW'(1);
            if (p_vld_ff && improve) begin
               dist_we              = 1'b1;
               relaxed_in[p_idx_ff] = 1'b1;
            end
            if (scan_done) begin
               j_in     = '0;
               found_in = 1'b0;
               if (!last_sel) sel_in = sel_ff + NB'(1);
            end
         end
         ST_OUT_RD: begin
         end
         ST_OUT_LD: begin
            o_idx_in   = NODE_W'(j_ff);
            o_dist_in  = relaxed_ff[rd_addr] ? dist_rd_ff :
                         ((rd_addr == '0) ? '0 : INF_DIST);
            o_par_in   = relaxed_ff[rd_addr] ? $signed(PAR_W'(pred_rd_ff)) : PARENT_NONE;
            o_reach_in = relaxed_ff[rd_addr] || (rd_addr == '0);
            o_rank_in  = RANK_W'(rank_rd_ff);
            o_last_in  = last_out;
         end
         ST_OUT_SEND: begin
            if (rsp_if.ready) j_in = j_ff + CW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         ncount_ff  <= NCOUNT_RESET;
         n_ff       <= CW'(1);
         j_ff       <= '0;
         p_vld_ff   <= 1'b0;
         sel_ff     <= '0;
         found_ff   <= 1'b0;
         settled_ff <= '0;
         relaxed_ff <= '0;
         clr_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         if (csr_valid) ncount_ff <= csr_node_count;
         n_ff       <= n_in;
         j_ff       <= j_in;
         p_vld_ff   <= p_vld_in;
         sel_ff     <= sel_in;
         found_ff   <= found_in;
         settled_ff <= settled_in;
         relaxed_ff <= relaxed_in;
         clr_ff     <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff   <= p_idx_in;
      cur_ff     <= cur_in;
      best_ff    <= best_in;
      o_idx_ff   <= o_idx_in;
      o_dist_ff  <= o_dist_in;
      o_par_ff   <= o_par_in;
      o_reach_ff <= o_reach_in;
      o_rank_ff  <= o_rank_in;
      o_last_ff  <= o_last_in;
   end

   // adjacency matrix: {present, weight}
   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
      if (issue) mat_rd_ff <= mat_mem[mat_ra];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[p_idx_ff] <= relax_sum[DIST_W-1:0];
         pred_mem[p_idx_ff] <= cur_ff;
      end
      if (rd_en) begin
         dist_rd_ff <= dist_mem[rd_addr];
         pred_rd_ff <= pred_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[cur_ff] <= sel_ff;
      if (rd_en) rank_rd_ff <= rank_mem[rd_addr];
   end

endmodule

// ----- hdl/dds_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the shortest-path top level, bound in below.
// Depends on dds_pkg and dense_dijkstra_shortest_path_top.
module dds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dds_pkg::NODE_W-1:0]        rsp_node_index,
   input logic [dds_pkg::DIST_W-1:0]        rsp_distance,
   input logic signed [dds_pkg::PAR_W-1:0]  rsp_parent,
   input logic                              rsp_reached,
   input logic                              rsp_last
);
   import dds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance) &&
                                  $stable(rsp_node_index) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while result beat pending");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("not idle after final result beat");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("idle before final result beat");

   a_unreached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reached ? (rsp_distance < INF_DIST) :
                     ((rsp_distance == INF_DIST) && (rsp_parent == PARENT_NONE))))
      else $error("reached flag inconsistent with distance or parent");

endmodule

bind dense_dijkstra_shortest_path_top dds_checker u_dds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_node_index (rsp_if.node_index),
   .rsp_distance   (rsp_if.path_distance),
   .rsp_parent     (rsp_if.parent_node),
   .rsp_reached    (rsp_if.reached),
   .rsp_last       (rsp_if.last_result)
);

// ----- tb/dds_path_checker.sv -----
`timescale 1ns / 1ps
// Watches the request, response and csr channels of the shortest-path engine, predicts
// every result beat from its own copy of the matrix and node count, and counts mismatches.
// Depends on dds_pkg and dds_if.
module dds_path_checker import dds_pkg::*; #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   dds_req_if                req_mon,
   dds_rsp_if                rsp_mon,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_node_count,
   output int                mismatches,
   output int                expected_left,
   output int                results_checked
);

   typedef struct {
      logic [NODE_W-1:0]        node_index;
      logic [DIST_W-1:0]        path_distance;
      logic signed [PAR_W-1:0]  parent_node;
      logic                     reached;
      logic [RANK_W-1:0]        visit_rank;
      logic                     last_result;
   } path_result_type;

   localparam int ENTRIES = MAX_NODES * MAX_NODES;

   path_result_type    expected_paths[$];
   logic [EWT_W-1:0]   edge_len [ENTRIES];
   logic               edge_on  [ENTRIES];
   logic [CNT_W-1:0]   node_count_reg;

   task automatic report_mismatch(input string what, input longint got, input longint want,
                                  input int node);
      if (mismatches < 40)
         $display("ERROR %0t ns node %0d %s: got %0d, expected %0d", $time, node, what, got,
                  want);
      mismatches++;
   endtask

   // Dense Dijkstra from node 0; lowest index wins ties, unreachable nodes settle last.
   function automatic void predict_paths();
      logic [DIST_W-1:0]        best_len   [MAX_NODES];
      logic signed [PAR_W-1:0]  prev_node  [MAX_NODES];
      logic                     is_settled [MAX_NODES];
      logic [RANK_W-1:0]        settle_pos [MAX_NODES];
      logic [31:0]              cand;
      path_result_type          res;
      int n, sel, cur, j, idx;
      n = node_count_reg;
      if (n == 0)
         n = 1;
      else if (n > MAX_NODES)
         n = MAX_NODES;
      for (j = 0; j < MAX_NODES; j++) begin
         best_len[j]   = INF_DIST;
         prev_node[j]  = PARENT_NONE;
         is_settled[j] = 1'b0;
         settle_pos[j] = '0;
      end
      best_len[0] = '0;
      for (sel = 0; sel < n; sel++) begin
         cur = -1;
         for (j = 0; j < n; j++)
            if (!is_settled[j] && (cur < 0 || best_len[j] < best_len[cur]))
               cur = j;
         is_settled[cur] = 1'b1;
         settle_pos[cur] = RANK_W'(sel);
         for (j = 0; j < n; j++) begin
            idx = cur * MAX_NODES + j;
            if (edge_on[idx]) begin
               cand = 32'(best_len[cur]) + 32'(edge_len[idx]);
               if (cand > 32'(INF_DIST))
                  cand = 32'(INF_DIST);
               if (cand < 32'(best_len[j])) begin
                  best_len[j]  = cand[DIST_W-1:0];
                  prev_node[j] = PAR_W'(cur);
               end
            end
         end
      end
      for (j = 0; j < n; j++) begin
         res.node_index    = NODE_W'(j);
         res.path_distance = best_len[j];
         res.parent_node   = prev_node[j];
         res.reached       = (best_len[j] < INF_DIST);
         res.visit_rank    = settle_pos[j];
         res.last_result   = (j == n - 1);
         expected_paths.push_back(res);
      end
   endfunction

   always @(posedge clock) begin
      path_result_type want;
      int idx;
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            edge_on[k]  = 1'b0;
            edge_len[k] = '0;
         end
         node_count_reg = NCOUNT_RESET;
         expected_paths.delete();
         mismatches      = 0;
         results_checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            node_count_reg = csr_node_count;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_WRITE) begin
               if (req_mon.from_node < MAX_NODES && req_mon.to_node < MAX_NODES) begin
                  idx = req_mon.from_node * MAX_NODES + req_mon.to_node;
                  edge_len[idx] = req_mon.edge_weight & EWT_W'((64'd1 << WEIGHT_BITS) - 1);
                  edge_on[idx]  = req_mon.edge_present;
               end
            end else begin
               predict_paths();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_checked++;
            if (expected_paths.size() == 0) begin
               report_mismatch("result beat with no run pending", rsp_mon.node_index, -1,
                               rsp_mon.node_index);
            end else begin
               want = expected_paths.pop_front();
               if (rsp_mon.node_index !== want.node_index)
                  report_mismatch("node_index", rsp_mon.node_index, want.node_index,
                                  want.node_index);
               if (rsp_mon.path_distance !== want.path_distance)
                  report_mismatch("path_distance", rsp_mon.path_distance, want.path_distance,
                                  want.node_index);
               if (rsp_mon.parent_node !== want.parent_node)
                  report_mismatch("parent_node", rsp_mon.parent_node, want.parent_node,
                                  want.node_index);
               if (rsp_mon.reached !== want.reached)
                  report_mismatch("reached", rsp_mon.reached, want.reached, want.node_index);
               if (rsp_mon.visit_rank !== want.visit_rank)
                  report_mismatch("visit_rank", rsp_mon.visit_rank, want.visit_rank,
                                  want.node_index);
               if (rsp_mon.last_result !== want.last_result)
                  report_mismatch("last_result", rsp_mon.last_result, want.last_result,
                                  want.node_index);
            end
         end
      end
      expected_left <= expected_paths.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the shortest-path engine testbench: clock, reset, request and csr stimulus,
// response pacing and the verdict. Depends on dds_pkg, dds_if, dds_path_checker and the RTL.
module testbench;
   import dds_pkg::*;

   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 800;
   localparam int PHASE_BEATS   = 60;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_node_count;
   logic              hold_off_req;
   int                mismatches;
   int                expected_left;
   int                results_checked;
   int                burst_left;
   int                beats_sent;
   int                runs_sent;
   int                settings_written;

   dds_req_if req_bus();
   dds_rsp_if rsp_bus();

   dense_dijkstra_shortest_path_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count)
   );

   dds_path_checker path_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_node_count  (csr_node_count),
      .mismatches      (mismatches),
      .expected_left   (expected_left),
      .results_checked (results_checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin : watchdog
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Response pacing: stretches of steady, random and periodic ready, plus one long hold.
   initial begin : rsp_pacing
      int mode, span, k;
      logic hold_done;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         for (k = 0; k < span; k++) begin
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
               default: rsp_bus.ready <= ((k % 8) < 5);
            endcase
            @(posedge clock);
         end
      end
   end

   function automatic logic [EWT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return EWT_W'($urandom_range(0, 15));
         4: return EWT_W'($urandom_range(0, 300));
         default: return EWT_W'($urandom);
      endcase
   endfunction

   task automatic send_beat(input logic kind, input logic [NODE_W-1:0] src,
                            input logic [NODE_W-1:0] dst, input logic [EWT_W-1:0] wt,
                            input logic present);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.from_node    <= src;
      req_bus.to_node      <= dst;
      req_bus.edge_weight  <= wt;
      req_bus.edge_present <= present;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      beats_sent++;
      if (kind == KIND_RUN)
         runs_sent++;
   endtask

   task automatic write_entry(input int src, input int dst, input logic [EWT_W-1:0] wt,
                              input logic present);
      send_beat(KIND_WRITE, NODE_W'(src), NODE_W'(dst), wt, present);
   endtask

   task automatic start_run();
      send_beat(KIND_RUN, NODE_W'($urandom), NODE_W'($urandom), EWT_W'($urandom),
                1'($urandom));
   endtask

   task automatic settle(input int extra);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_node_count(input logic [CNT_W-1:0] value);
      settle(SETTLE_CYCLES);
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0] phase_counts [8];
      int p, i, roll, active;
      reset                = 1'b1;
      hold_off_req         = 1'b0;
      csr_valid            = 1'b0;
      csr_node_count       = NCOUNT_RESET;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_WRITE;
      req_bus.from_node    = '0;
      req_bus.to_node      = '0;
      req_bus.edge_weight  = '0;
      req_bus.edge_present = 1'b0;
      burst_left           = 0;
      beats_sent           = 0;
      runs_sent            = 0;
      settings_written     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_node_count(5'd16);
      start_run();
      write_entry(0, 1, 16'd0, 1'b1);
      write_entry(0, 15, 16'hFFFF, 1'b1);
      write_entry(1, 2, 16'd5, 1'b1);
      write_entry(2, 15, 16'd3, 1'b1);
      write_entry(3, 3, 16'd9, 1'b1);
      write_entry(0, 4, 16'd1, 1'b1);
      write_entry(0, 4, 16'd1, 1'b0);
      write_entry(7, 8, 16'd10, 1'b1);
      write_entry(0, 5, 16'd7, 1'b1);
      write_entry(0, 6, 16'd7, 1'b1);
      write_entry(5, 9, 16'd2, 1'b1);
      write_entry(6, 9, 16'd2, 1'b1);
      write_entry(15, 14, 16'hFFFF, 1'b1);
      write_entry(14, 13, 16'hFFFF, 1'b1);
      write_entry(9, 0, 16'd4, 1'b1);
      write_entry(15, 15, 16'hFFFF, 1'b1);
      send_beat(KIND_RUN, 4'hF, 4'hF, 16'hFFFF, 1'b1);
      set_node_count(5'd0);
      start_run();
      set_node_count(5'd31);
      start_run();

      phase_counts = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd7, 5'd16, 5'd17,
                       CNT_W'($urandom_range(1, 16))};
      for (p = 0; p < 8; p++) begin
         set_node_count(phase_counts[p]);
         if (phase_counts[p] == 5'd16)
            hold_off_req <= 1'b1;
         active = (phase_counts[p] == 0) ? 1 : (phase_counts[p] > 16) ? 16 : phase_counts[p];
         for (i = 0; i < PHASE_BEATS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 14)
               start_run();
            else if (roll < 84)
               write_entry($urandom_range(0, active - 1), $urandom_range(0, active - 1),
                           pick_weight(), $urandom_range(0, 4) != 0);
            else
               write_entry($urandom_range(0, 15), $urandom_range(0, 15), pick_weight(),
                           1'($urandom));
         end
         start_run();
      end

      settle(DRAIN_CYCLES);
      $display("Covered %0d request beats, %0d of them path runs, across %0d node-count settings.",
               beats_sent, runs_sent, settings_written);
      $display("Checked %0d result beats against predicted distances, parents and ranks.",
               results_checked);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- dense_dijkstra_shortest_path_top.f -----
hdl/dds_pkg.sv
hdl/dds_if.sv
hdl/dense_dijkstra_shortest_path_top.sv
hdl/dds_checker.sv
tb/dds_path_checker.sv
tb/testbench.sv
